/* design/sorted_priority_queue_top_macros.svh */
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_macros.svh
// Assertion helpers shared by the queue checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;
    localparam int IN_W     = 72;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    // one stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_cmd;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [OCC_W-1:0]         occupancy;
        logic                     was_full;
        logic                     was_empty;
        logic                     out_valid;
        logic signed [DATA_W-1:0] out_value;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

/* design/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// behind the insertion point and left on removal of the head.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occupied,   // slot below the entry count
    input  spq_pkg::t_entry    i_new,        // entry being enqueued
    input  spq_pkg::t_entry    i_left,       // neighbor toward the head
    input  spq_pkg::t_entry    i_right,      // neighbor toward the tail
    input  logic               i_ins_left,   // insertion point at or before left
    output spq_pkg::t_entry    o_entry,
    output logic               o_ins         // insertion point at or before here
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_lower;

    // new entry goes ahead of a stored one of strictly lower priority
    assign w_lower = $signed(r_entry.prio) < $signed(i_new.prio);
    assign o_ins   = !i_occupied || w_lower;

    // next slot contents
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.deq) begin
            n_entry = i_right;
        end else if (i_cmd.enq && o_ins) begin
            if (i_ins_left) begin
                n_entry = i_left;
            end else begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

/* design/sorted_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue of (value, priority) entries in a chain of cells.
// ----------------------------------------------------------------------------
// Each accepted item is a single enqueue or dequeue; all CAPACITY cells
// compare against the new priority in parallel and shift in the same clock
// that accepts the item, and its result is registered by that same edge.
// One item per cycle is sustained while the result side takes
// items; the only stall comes from the single output register, which frees
// the input whenever its result is taken in the same cycle. Equal priorities
// leave in arrival order; an enqueue on a full queue is dropped and flagged.
module sorted_priority_queue_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // op [0], value [32:1], priority_req [64:33], zero pad [71:65]
    input  logic [spq_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // out_value [31:0], out_valid [32], was_empty [33], was_full [34],
    // occupancy [39:35]
    output logic [spq_pkg::RES_W-1:0]  o_m_axis_tdata
);
    import spq_pkg::*;

    logic             w_acc;
    t_op              w_op;
    t_entry           w_new;
    logic             w_full;
    logic             w_empty;
    t_cell_cmd        w_cmd;
    t_entry           w_entry [CAPACITY];
    logic             w_ins   [CAPACITY];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_m_valid;
    logic             n_m_valid;
    t_result          r_res;
    t_result          n_res;

    // input decode
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op            = t_op'(i_s_axis_tdata[0]);
    assign w_new.value     = i_s_axis_tdata[DATA_W:1];
    assign w_new.prio      = i_s_axis_tdata[2*DATA_W:DATA_W+1];
    assign w_full          = r_count == CNT_W'(CAPACITY);
    assign w_empty         = r_count == '0;
    assign w_cmd.enq       = w_acc && (w_op == OP_ENQ) && !w_full;
    assign w_cmd.deq       = w_acc && (w_op == OP_DEQ) && !w_empty;

    // chain of cells, slot 0 is the head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_ins_left;
        if (g == 0) begin : g_head
            assign w_left     = w_new;
            assign w_ins_left = 1'b0;
        end else begin : g_mid
            assign w_left     = w_entry[g-1];
            assign w_ins_left = w_ins[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end
        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_occupied (r_count > CNT_W'(g)),
            .i_new      (w_new),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_ins_left (w_ins_left),
            .o_entry    (w_entry[g]),
            .o_ins      (w_ins[g])
        );
    end

    // count and result
    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.deq) begin
            n_count = r_count - CNT_W'(1);
        end
        n_res.out_value = w_cmd.deq ? w_entry[0].value : '0;
        n_res.out_valid = w_cmd.deq;
        n_res.was_empty = (w_op == OP_DEQ) && w_empty;
        n_res.was_full  = (w_op == OP_ENQ) && w_full;
        n_res.occupancy = OCC_W'(n_count);
    end

    // output register handshake
    always_comb begin
        n_m_valid = r_m_valid;
        if (w_acc) begin
            n_m_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_res;

endmodule

/* design/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_macros.svh"

module spq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic [spq_pkg::IN_W-1:0]   i_s_axis_tdata,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [spq_pkg::RES_W-1:0]  o_m_axis_tdata
);
    import spq_pkg::*;

    t_result w_res;
    logic    w_in_acc;

    assign w_res    = o_m_axis_tdata;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata[0] == 1'b0);

    // a stalled result stays put
    `SPQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // returned and empty are exclusive, and no value leaks without a return
    `SPQ_ASSERT_NOW(a_flags, i_clk, i_rst_n,
        o_m_axis_tvalid,
        !(w_res.out_valid && w_res.was_empty) && (w_res.out_valid || w_res.out_value == '0))
    // a dropped enqueue only happens at full capacity
    `SPQ_ASSERT_NOW(a_full, i_clk, i_rst_n,
        o_m_axis_tvalid && w_res.was_full,
        w_res.occupancy == OCC_W'(CAPACITY))
    // an empty dequeue reports zero entries
    `SPQ_ASSERT_NOW(a_empty, i_clk, i_rst_n,
        o_m_axis_tvalid && w_res.was_empty,
        w_res.occupancy == '0)
    // an accepted enqueue never reports a dequeue outcome
    `SPQ_ASSERT_NEXT(a_enq, i_clk, i_rst_n,
        w_in_acc,
        o_m_axis_tvalid && !w_res.out_valid && !w_res.was_empty)

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* sim/sorted_priority_queue_top_test.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_test
// Self-checking testbench of the sorted priority queue.
// ----------------------------------------------------------------------------
// A directed table comes first. It covers a dequeue on an empty queue,
// enqueues of the extreme values and priorities, ties at the top, at the
// bottom and in the middle, a fill up to capacity, an enqueue that is
// dropped because the queue is full, and dequeues in priority order.
// Random phases follow. They move between enqueue-heavy and dequeue-heavy
// traffic, so the queue keeps running into its full and empty limits, and
// the priorities are drawn narrow enough that ties are frequent.
// Every accepted item runs through a local model of the queue. Each result
// is checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int IDLE_PCT    = 14;
    localparam int RAND_ITEMS  = 1325;
    localparam int STUCK_LIMIT = 1000;
    localparam int MAX_REPORTS = 40;

    // results that are plain from the table itself
    localparam t_result RES_EMPTY_DEQ = '{occupancy: 5'd0, was_full: 1'b0, was_empty: 1'b1,
                                          out_valid: 1'b0, out_value: 32'sd0};
    localparam t_result RES_FIRST_ENQ = '{occupancy: 5'd1, was_full: 1'b0, was_empty: 1'b0,
                                          out_valid: 1'b0, out_value: 32'sd0};
    localparam t_result RES_FULL_ENQ  = '{occupancy: OCC_W'(CAPACITY), was_full: 1'b1,
                                          was_empty: 1'b0, out_valid: 1'b0,
                                          out_value: 32'sd0};
    localparam t_result RES_TOP_DEQ   = '{occupancy: OCC_W'(CAPACITY - 1), was_full: 1'b0,
                                          was_empty: 1'b0, out_valid: 1'b1,
                                          out_value: 32'sh7fff_ffff};
    localparam t_result NO_RES        = '0;

    typedef struct {
        bit      pinned;
        t_result res;
    } t_pin;

    typedef struct {
        t_op         op;
        logic [31:0] value;
        logic [31:0] prio;
        bit          pinned;
        t_result     res;
    } t_stim_row;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [RES_W-1:0]  m_tdata;

    bit                no_gaps;
    int                err_count;
    int                results_seen;
    int                stuck_cycles;

    t_entry            held_entries[$];
    t_result           expected_results[$];
    t_pin              pinned_rows[$];

    // directed table: extremes, ties, fill to capacity, drop when full, dequeues
    t_stim_row directed_rows [25] = '{
        '{OP_DEQ, 32'h0000_0000, 32'h0000_0000, 1'b1, RES_EMPTY_DEQ},
        '{OP_ENQ, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, RES_FIRST_ENQ},
        '{OP_ENQ, 32'h8000_0000, 32'h8000_0000, 1'b0, NO_RES},
        '{OP_ENQ, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_ENQ, 32'hffff_ffff, 32'hffff_ffff, 1'b0, NO_RES},
        '{OP_ENQ, 32'h0000_0001, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_ENQ, 32'h5555_5555, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_ENQ, 32'haaaa_aaaa, 32'h7fff_ffff, 1'b0, NO_RES},
        '{OP_ENQ, 32'h1234_5678, 32'h8000_0000, 1'b0, NO_RES},
        '{OP_ENQ, 32'h0000_abcd, 32'h0000_0001, 1'b0, NO_RES},
        '{OP_ENQ, 32'h7fff_fffe, 32'h7fff_fffe, 1'b0, NO_RES},
        '{OP_ENQ, 32'h8000_0001, 32'h8000_0001, 1'b0, NO_RES},
        '{OP_ENQ, 32'h0f0f_0f0f, 32'h0000_0064, 1'b0, NO_RES},
        '{OP_ENQ, 32'hf0f0_f0f0, 32'hffff_ff9c, 1'b0, NO_RES},
        '{OP_ENQ, 32'h0000_0002, 32'h0000_0000, 1'b0, NO_RES},
        '{OP_ENQ, 32'h3333_3333, 32'h4000_0000, 1'b0, NO_RES},
        '{OP_ENQ, 32'hcccc_cccc, 32'hc000_0000, 1'b0, NO_RES},
        '{OP_ENQ, 32'hdead_beef, 32'h7fff_ffff, 1'b1, RES_FULL_ENQ},
        '{OP_DEQ, 32'h0000_0000, 32'h0000_0000, 1'b1, RES_TOP_DEQ},
        '{OP_DEQ, 32'hffff_ffff, 32'hffff_ffff, 1'b0, NO_RES},
        '{OP_DEQ, 32'h8000_0000, 32'h7fff_ffff, 1'b0, NO_RES},
        '{OP_DEQ, 32'h7fff_ffff, 32'h8000_0000, 1'b0, NO_RES},
        '{OP_DEQ, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, NO_RES},
        '{OP_DEQ, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, NO_RES},
        '{OP_DEQ, 32'h0000_0000, 32'hffff_ffff, 1'b0, NO_RES}
    };

    sorted_priority_queue_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // queue model: sorted by priority, ties leave in arrival order
    function automatic t_result apply_queue_op(t_op op, logic signed [31:0] val,
                                               logic signed [31:0] pri);
        t_result r;
        t_entry  e;
        int      slot;
        r = '0;
        if (op == OP_ENQ) begin
            if (held_entries.size() >= CAPACITY) begin
                r.was_full = 1'b1;
            end else begin
                slot = held_entries.size();
                for (int i = 0; i < held_entries.size(); i++) begin
                    if (held_entries[i].prio < pri) begin
                        slot = i;
                        break;
                    end
                end
                e.prio  = pri;
                e.value = val;
                held_entries.insert(slot, e);
            end
        end else begin
            if (held_entries.size() == 0) begin
                r.was_empty = 1'b1;
            end else begin
                r.out_value = held_entries[0].value;
                r.out_valid = 1'b1;
                void'(held_entries.pop_front());
            end
        end
        r.occupancy = OCC_W'(held_entries.size());
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH result %0d %s: got %0h, expected %0h",
                     results_seen, field, got, want);
    endtask

    // drive one item at the falling edge, hold until accepted
    task automatic push_item(t_op op, logic [31:0] val, logic [31:0] pri,
                             bit pinned, t_result res);
        t_pin pin;
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        pin.pinned = pinned;
        pin.res    = res;
        pinned_rows.push_back(pin);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pri, val, op};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending until every outstanding result is back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // result side stalls at random
    always @(negedge clk) begin
        m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    // predict on input handshakes, check on output handshakes
    always @(posedge clk) begin
        t_result got_res;
        t_result want_res;
        t_pin    pin;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                want_res = apply_queue_op(t_op'(s_tdata[0]), s_tdata[32:1], s_tdata[64:33]);
                if (pinned_rows.size() != 0) begin
                    pin = pinned_rows.pop_front();
                    if (pin.pinned)
                        want_res = pin.res;
                end
                expected_results.push_back(want_res);
            end
            if (m_tvalid && m_tready) begin
                got_res = t_result'(m_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", got_res.out_value, 32'd0);
                end else begin
                    want_res = expected_results.pop_front();
                    if (got_res.out_value !== want_res.out_value)
                        report_mismatch("out_value", got_res.out_value, want_res.out_value);
                    if (got_res.out_valid !== want_res.out_valid)
                        report_mismatch("out_valid", got_res.out_valid, want_res.out_valid);
                    if (got_res.was_empty !== want_res.was_empty)
                        report_mismatch("was_empty", got_res.was_empty, want_res.was_empty);
                    if (got_res.was_full !== want_res.was_full)
                        report_mismatch("was_full", got_res.was_full, want_res.was_full);
                    if (got_res.occupancy !== want_res.occupancy)
                        report_mismatch("occupancy", got_res.occupancy, want_res.occupancy);
                end
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // watchdog: no handshake on either side for too long
    initial begin
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
        $display("sorted_priority_queue_top_test: errors");
        $finish;
    end

    // stimulus
    initial begin
        int          enq_pct;
        int          phase_left;
        int          mode;
        t_op         op;
        logic [31:0] val;
        logic [31:0] pri;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        no_gaps      = 1'b0;
        err_count    = 0;
        results_seen = 0;
        enq_pct      = 50;
        phase_left   = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].prio,
                      directed_rows[i].pinned, directed_rows[i].res);
        drain_results();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // new traffic mix every few dozen items
            if (phase_left == 0) begin
                case ($urandom_range(3))
                    0:       enq_pct = 10;
                    1:       enq_pct = 50;
                    2:       enq_pct = 75;
                    default: enq_pct = 97;
                endcase
                phase_left = $urandom_range(40, 80);
            end
            phase_left--;
            no_gaps = (n >= 300 && n < 600);
            if (n % 300 == 150)
                drain_results();

            op   = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            val  = $urandom;
            mode = $urandom_range(99);
            // narrow priorities make ties common
            if (mode < 60) begin
                pri = 32'($urandom_range(6)) - 32'd3;
            end else if (mode < 85) begin
                pri = $urandom;
            end else begin
                case ($urandom_range(3))
                    0:       pri = 32'h8000_0000;
                    1:       pri = 32'h7fff_ffff;
                    2:       pri = 32'h0000_0000;
                    default: pri = 32'hffff_ffff;
                endcase
            end
            push_item(op, val, pri, 1'b0, NO_RES);
        end

        no_gaps = 1'b0;
        drain_results();
        repeat (4) @(posedge clk);

        if (err_count == 0)
            $display("sorted_priority_queue_top_test: clean");
        else
            $display("sorted_priority_queue_top_test: errors");
        $finish;
    end

endmodule
